@@ rtl/core/pklph_pkg.sv @@
`timescale 1ns / 1ps

package pklph_pkg;

   localparam int KEY_W     = 31;
   localparam int PAIR_W    = 2 * KEY_W;
   localparam int FIELD_W   = 12;
   localparam int COUNT_W   = 13;
   localparam int MULT_W    = 64;
   localparam int HALF_W    = 32;
   localparam int CSR_IDX_W = 1;

   localparam logic [COUNT_W-1:0] LOAD_LIMIT_RESET = 13'd3072;

   localparam logic [CSR_IDX_W-1:0] CSR_HASH_MULT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOAD_LIMIT = 1'd1;

   typedef enum logic [1:0] {
      OP_SEARCH     = 2'd0,
      OP_INSERT     = 2'd1,
      OP_DELETE     = 2'd2,
      OP_REPOSITION = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      TAG_EMPTY = 2'd0,
      TAG_TOMB  = 2'd1,
      TAG_LIVE  = 2'd2
   } tag_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH_A,
      ST_HASH_B,
      ST_HASH_C,
      ST_HASH_MOD,
      ST_PROBE,
      ST_SLOT_CHK,
      ST_ID_CHK,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_REPO,
      ST_RESP
   } state_type;

   typedef struct packed {
      opcode_type         opcode;
      logic [KEY_W-1:0]   key_left;
      logic [KEY_W-1:0]   key_right;
      logic [FIELD_W-1:0] entry_id;
      logic [FIELD_W-1:0] target_slot;
   } req_payload_type;

   typedef struct packed {
      logic               found;
      logic [FIELD_W-1:0] result_id;
      logic [FIELD_W-1:0] result_slot;
      logic               status;
   } rsp_payload_type;

endpackage

@@ rtl/core/pklph_stream_if.sv @@
`timescale 1ns / 1ps

interface pklph_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/pklph_ram.sv @@
`timescale 1ns / 1ps

module pklph_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read returns old data on a same-address write
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/pair_key_linear_probe_hash_unit.sv @@
`timescale 1ns / 1ps
// per accepted beat: search and insert hash the pair, then walk the slots, search comparing
//   the id record of each live slot; delete reads the id record, then tombstones; reposition
//   writes both rams; refused or bad beats skip to the response; non power-of-two slots add a mod
// throughput: one operation at a time, set by the probe walk over the slot ram (one read port)
// reset: synchronous, active high; then a sweep over every slot marks each one empty,
//   during which no request beat is taken (csr writes are taken as ever)

module pair_key_linear_probe_hash_unit #(
   parameter int TABLE_SLOTS = 4096,
   parameter int MAX_IDS     = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   pklph_stream_if.sink                         req_bus,
   pklph_stream_if.source                       rsp_bus,
   input  logic                                 csr_write_en,
   input  logic [pklph_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pklph_pkg::MULT_W-1:0]         csr_write_data
);

   // slot and id widths
   localparam int SW      = $clog2(TABLE_SLOTS);
   localparam int IW      = $clog2(MAX_IDS);
   localparam int SLOT_W  = 2 + IW;                      // {tag, id}
   localparam int IDREC_W = pklph_pkg::PAIR_W + SW;      // {pair, slot}
   localparam bit SLOTS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;

   localparam logic [SW-1:0] SLOT_LAST = SW'(TABLE_SLOTS - 1);
   localparam logic [SW:0]   SLOTS_K   = (SW + 1)'(TABLE_SLOTS);
   localparam logic [31:0]   MAX_IDS_K = 32'(MAX_IDS);
   localparam logic [31:0]   SLOTS_32  = 32'(TABLE_SLOTS);
   localparam logic [4:0]    MOD_STEPS = 5'd31;

   // ---------------------------------------------------------------- registers
   pklph_pkg::state_type           state_ff, state_in;
   logic [SW-1:0]                  slot_ff, slot_in;          // probe slot, clear pointer, remainder
   logic [SW-1:0]                  probe_cnt_ff, probe_cnt_in;
   logic [pklph_pkg::HALF_W-1:0]   acc_ff, acc_in;            // hash bits 63:32
   logic [4:0]                     mod_cnt_ff, mod_cnt_in;
   pklph_pkg::opcode_type          op_ff, op_in;
   logic [pklph_pkg::PAIR_W-1:0]   pair_ff, pair_in;
   logic [IW-1:0]                  id_ff, id_in;
   logic [IW-1:0]                  hit_id_ff, hit_id_in;
   pklph_pkg::rsp_payload_type     res_ff, res_in;            // staged result
   logic                           rsp_valid_ff, rsp_valid_in;
   pklph_pkg::rsp_payload_type     rsp_payload_ff, rsp_payload_in;
   logic [pklph_pkg::COUNT_W-1:0]  live_count_ff, live_count_in;
   logic [pklph_pkg::MULT_W-1:0]   hash_mult_ff, hash_mult_in;
   logic [pklph_pkg::COUNT_W-1:0]  load_limit_ff, load_limit_in;

   // ---------------------------------------------------------------- ram ports
   logic                 slot_we;
   logic [SW-1:0]        slot_waddr, slot_raddr;
   logic [SLOT_W-1:0]    slot_wdata, slot_rdata;
   logic                 idrec_we;
   logic [IW-1:0]        idrec_waddr, idrec_raddr;
   logic [IDREC_W-1:0]   idrec_wdata, idrec_rdata;

   pklph_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_SLOTS)) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_waddr),
      .wdata (slot_wdata),
      .raddr (slot_raddr),
      .rdata (slot_rdata)
   );

   // pair and occupied slot per id, written together by insert and reposition
   pklph_ram #(.WIDTH(IDREC_W), .DEPTH(MAX_IDS)) u_idrec_ram (
      .clock (clock),
      .we    (idrec_we),
      .waddr (idrec_waddr),
      .wdata (idrec_wdata),
      .raddr (idrec_raddr),
      .rdata (idrec_rdata)
   );

   // ---------------------------------------------------------------- shared decode
   logic                         req_fire;
   logic                         out_free;
   logic                         id_ok, tslot_ok;
   logic                         insert_room;
   logic [SW-1:0]                slot_next;
   pklph_pkg::tag_type           rd_tag;
   logic [IW-1:0]                rd_id;
   logic                         is_search;
   logic                         chk_place, chk_to_id, chk_stop, chk_skip;
   logic                         probe_last;
   logic                         pair_hit;
   logic [SW:0]                  rem_dbl, rem_red;

   assign req_fire    = (state_ff == pklph_pkg::ST_IDLE) && req_bus.valid;
   assign out_free    = !rsp_valid_ff || rsp_bus.ready;
   assign id_ok       = {20'd0, req_bus.payload.entry_id} < MAX_IDS_K;
   assign tslot_ok    = {20'd0, req_bus.payload.target_slot} < SLOTS_32;
   assign insert_room = live_count_ff < load_limit_ff;

   // linear probe with wraparound
   assign slot_next = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;

   assign rd_tag     = pklph_pkg::tag_type'(slot_rdata[SLOT_W-1 -: 2]);
   assign rd_id      = slot_rdata[IW-1:0];
   assign is_search  = op_ff == pklph_pkg::OP_SEARCH;
   assign probe_last = probe_cnt_ff == SLOT_LAST;
   assign pair_hit   = idrec_rdata[IDREC_W-1 -: pklph_pkg::PAIR_W] == pair_ff;

   // slot check outcomes: insert takes any non-live slot, search stops on empty,
   // goes to the id record on live, and walks over tombstones
   assign chk_place = !is_search && (rd_tag != pklph_pkg::TAG_LIVE);
   assign chk_to_id = is_search && (rd_tag == pklph_pkg::TAG_LIVE);
   assign chk_stop  = is_search && (rd_tag == pklph_pkg::TAG_EMPTY);
   assign chk_skip  = !chk_place && !chk_to_id && !chk_stop;

   // one restoring step of hash mod TABLE_SLOTS
   assign rem_dbl = {slot_ff, acc_ff[pklph_pkg::HALF_W-1]};
   assign rem_red = (rem_dbl >= SLOTS_K) ? rem_dbl - SLOTS_K : rem_dbl;

   // ---------------------------------------------------------------- shared multiplier
   // low 64 bits of mult * {left, right}, each key zero-extended to 32 bits: bits 63:32 need lo*lo high half plus the
   // low halves of both cross products
   logic [pklph_pkg::HALF_W-1:0]   mul_a, mul_b;
   logic [pklph_pkg::MULT_W-1:0]   mul_p;

   always_comb begin
      mul_a = hash_mult_ff[pklph_pkg::HALF_W-1:0];
      mul_b = {1'b0, pair_ff[pklph_pkg::KEY_W-1:0]};
      case (state_ff)
         pklph_pkg::ST_HASH_B: begin
            mul_b = {1'b0, pair_ff[pklph_pkg::PAIR_W-1 -: pklph_pkg::KEY_W]};
         end
         pklph_pkg::ST_HASH_C: begin
            mul_a = hash_mult_ff[pklph_pkg::MULT_W-1 -: pklph_pkg::HALF_W];
         end
         default: begin
         end
      endcase
   end

   assign mul_p = pklph_pkg::MULT_W'(mul_a) * pklph_pkg::MULT_W'(mul_b);

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pklph_pkg::ST_CLEAR: begin
            if (slot_ff == SLOT_LAST) state_in = pklph_pkg::ST_IDLE;
         end
         pklph_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_bus.payload.opcode)
                  pklph_pkg::OP_SEARCH: state_in = pklph_pkg::ST_HASH_A;
                  pklph_pkg::OP_INSERT: begin
                     state_in = (id_ok && insert_room) ? pklph_pkg::ST_HASH_A
                                                       : pklph_pkg::ST_RESP;
                  end
                  pklph_pkg::OP_DELETE: begin
                     state_in = id_ok ? pklph_pkg::ST_DEL_RD : pklph_pkg::ST_RESP;
                  end
                  pklph_pkg::OP_REPOSITION: begin
                     state_in = (id_ok && tslot_ok) ? pklph_pkg::ST_REPO
                                                    : pklph_pkg::ST_RESP;
                  end
                  default: state_in = pklph_pkg::ST_RESP;
               endcase
            end
         end
         pklph_pkg::ST_HASH_A: state_in = pklph_pkg::ST_HASH_B;
         pklph_pkg::ST_HASH_B: state_in = pklph_pkg::ST_HASH_C;
         pklph_pkg::ST_HASH_C: begin
            state_in = SLOTS_POW2 ? pklph_pkg::ST_PROBE : pklph_pkg::ST_HASH_MOD;
         end
         pklph_pkg::ST_HASH_MOD: begin
            if (mod_cnt_ff == '0) state_in = pklph_pkg::ST_PROBE;
         end
         pklph_pkg::ST_PROBE: state_in = pklph_pkg::ST_SLOT_CHK;
         pklph_pkg::ST_SLOT_CHK: begin
            if (chk_to_id) begin
               state_in = pklph_pkg::ST_ID_CHK;
            end else if (chk_place || chk_stop || probe_last) begin
               state_in = pklph_pkg::ST_RESP;
            end
         end
         pklph_pkg::ST_ID_CHK: begin
            state_in = (pair_hit || probe_last) ? pklph_pkg::ST_RESP
                                                : pklph_pkg::ST_SLOT_CHK;
         end
         pklph_pkg::ST_DEL_RD: state_in = pklph_pkg::ST_DEL_WR;
         pklph_pkg::ST_DEL_WR: state_in = pklph_pkg::ST_RESP;
         pklph_pkg::ST_REPO:   state_in = pklph_pkg::ST_RESP;
         pklph_pkg::ST_RESP: begin
            if (out_free) state_in = pklph_pkg::ST_IDLE;
         end
         default: state_in = pklph_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- datapath and ram control
   always_comb begin
      slot_in        = slot_ff;
      probe_cnt_in   = probe_cnt_ff;
      acc_in         = acc_ff;
      mod_cnt_in     = mod_cnt_ff;
      op_in          = op_ff;
      pair_in        = pair_ff;
      id_in          = id_ff;
      hit_id_in      = hit_id_ff;
      res_in         = res_ff;
      live_count_in  = live_count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_payload_in = rsp_payload_ff;

      slot_we     = 1'b0;
      slot_waddr  = slot_ff;
      slot_wdata  = {pklph_pkg::TAG_LIVE, id_ff};
      idrec_we    = 1'b0;
      idrec_waddr = id_ff;
      idrec_wdata = {pair_ff, slot_ff};

      // probe reads run one slot ahead so a skipped slot's data is ready when the walk steps onto it
      slot_raddr  = (state_ff == pklph_pkg::ST_PROBE) ? slot_ff : slot_next;
      idrec_raddr = (state_ff == pklph_pkg::ST_SLOT_CHK) ? rd_id : id_ff;

      case (state_ff)
         pklph_pkg::ST_CLEAR: begin
            slot_we    = 1'b1;
            slot_wdata = {pklph_pkg::TAG_EMPTY, {IW{1'b0}}};
            slot_in    = slot_next;
         end
         pklph_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in   = req_bus.payload.opcode;
               pair_in = {req_bus.payload.key_left, req_bus.payload.key_right};
               id_in   = IW'(req_bus.payload.entry_id);
               slot_in = SW'(req_bus.payload.target_slot);
               res_in  = '0;
               if (req_bus.payload.opcode == pklph_pkg::OP_INSERT && id_ok && !insert_room) begin
                  res_in.status = 1'b1;
               end
            end
         end
         pklph_pkg::ST_HASH_A: begin
            acc_in = mul_p[pklph_pkg::MULT_W-1 -: pklph_pkg::HALF_W];
         end
         pklph_pkg::ST_HASH_B: begin
            acc_in = acc_ff + mul_p[pklph_pkg::HALF_W-1:0];
         end
         pklph_pkg::ST_HASH_C: begin
            acc_in     = acc_ff + mul_p[pklph_pkg::HALF_W-1:0];
            slot_in    = SLOTS_POW2 ? acc_in[SW-1:0] : '0;
            mod_cnt_in = MOD_STEPS;
         end
         pklph_pkg::ST_HASH_MOD: begin
            slot_in    = rem_red[SW-1:0];
            acc_in     = {acc_ff[pklph_pkg::HALF_W-2:0], 1'b0};
            mod_cnt_in = mod_cnt_ff - 1'b1;
         end
         pklph_pkg::ST_PROBE: begin
            probe_cnt_in = '0;
         end
         pklph_pkg::ST_SLOT_CHK: begin
            hit_id_in = rd_id;
            if (chk_place) begin
               slot_we        = 1'b1;
               idrec_we       = 1'b1;
               live_count_in  = live_count_ff + 1'b1;
               res_in.result_slot = pklph_pkg::FIELD_W'(slot_ff);
            end else if (chk_skip) begin
               if (probe_last) begin
                  // every slot visited: insert is full, search misses
                  res_in.status = !is_search;
               end else begin
                  slot_in      = slot_next;
                  probe_cnt_in = probe_cnt_ff + 1'b1;
               end
            end
         end
         pklph_pkg::ST_ID_CHK: begin
            if (pair_hit) begin
               res_in.found       = 1'b1;
               res_in.result_id   = pklph_pkg::FIELD_W'(hit_id_ff);
               res_in.result_slot = pklph_pkg::FIELD_W'(slot_ff);
            end else if (!probe_last) begin
               slot_in      = slot_next;
               probe_cnt_in = probe_cnt_ff + 1'b1;
            end
         end
         pklph_pkg::ST_DEL_WR: begin
            // tombstone whatever the recorded slot holds
            slot_we    = 1'b1;
            slot_waddr = idrec_rdata[SW-1:0];
            slot_wdata = {pklph_pkg::TAG_TOMB, {IW{1'b0}}};
            if (live_count_ff != '0) live_count_in = live_count_ff - 1'b1;
         end
         pklph_pkg::ST_REPO: begin
            slot_we  = 1'b1;
            idrec_we = 1'b1;
         end
         pklph_pkg::ST_RESP: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------- csr writes
   always_comb begin
      hash_mult_in  = hash_mult_ff;
      load_limit_in = load_limit_ff;
      if (csr_write_en) begin
         case (csr_index)
            pklph_pkg::CSR_HASH_MULT:  hash_mult_in  = csr_write_data;
            pklph_pkg::CSR_LOAD_LIMIT: load_limit_in = csr_write_data[pklph_pkg::COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pklph_pkg::ST_CLEAR;
         slot_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         live_count_ff <= '0;
         hash_mult_ff  <= '0;
         load_limit_ff <= pklph_pkg::LOAD_LIMIT_RESET;
      end else begin
         state_ff      <= state_in;
         slot_ff       <= slot_in;
         rsp_valid_ff  <= rsp_valid_in;
         live_count_ff <= live_count_in;
         hash_mult_ff  <= hash_mult_in;
         load_limit_ff <= load_limit_in;
      end
   end

   // ---------------------------------------------------------------- payload registers
   always_ff @(posedge clock) begin
      probe_cnt_ff   <= probe_cnt_in;
      acc_ff         <= acc_in;
      mod_cnt_ff     <= mod_cnt_in;
      op_ff          <= op_in;
      pair_ff        <= pair_in;
      id_ff          <= id_in;
      hit_id_ff      <= hit_id_in;
      res_ff         <= res_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // ---------------------------------------------------------------- ports
   assign req_bus.ready   = state_ff == pklph_pkg::ST_IDLE;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_payload_ff;

   // ---------------------------------------------------------------- assertions
   // insert never overwrites a live slot
   a_place_not_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pklph_pkg::ST_SLOT_CHK && slot_we) |-> rd_tag != pklph_pkg::TAG_LIVE)
      else $error("insert wrote over a live slot");

   // a placement only happens below the load limit
   a_place_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pklph_pkg::ST_SLOT_CHK && idrec_we) |-> live_count_ff < load_limit_ff)
      else $error("insert placed at or above load limit");

   // a refused insert carries no slot and no hit
   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.payload.status) |->
         (rsp_bus.payload.result_slot == '0 && !rsp_bus.payload.found))
      else $error("full result carries slot or hit");

   // staged result reaches the output register when it is free
   a_resp_moves: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pklph_pkg::ST_RESP && out_free) |=>
         (rsp_bus.valid && state_ff == pklph_pkg::ST_IDLE))
      else $error("staged result not delivered");

   // the id record is read only for a live slot during search
   a_id_chk_search: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pklph_pkg::ST_ID_CHK) |-> (is_search && $past(rd_tag) == pklph_pkg::TAG_LIVE))
      else $error("id compare outside a live search probe");

endmodule
